[design/sslp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sslp_pkg;

    localparam int NAME_MAX_BYTES = 32;
    localparam logic [7:0] LAST_POS = 8'(NAME_MAX_BYTES - 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_TEXCOUNT = 4'd0,
        PH_TEXNAME  = 4'd1,
        PH_WIDTH    = 4'd2,
        PH_HEIGHT   = 4'd3,
        PH_COUNT    = 4'd4,
        PH_NAME     = 4'd5,
        PH_X        = 4'd6,
        PH_Y        = 4'd7,
        PH_W        = 4'd8,
        PH_H        = 4'd9,
        PH_DONE     = 4'd10,
        PH_HALT     = 4'd11
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_NAME_BYTE = 3'd1,
        KIND_GEOMETRY  = 3'd2,
        KIND_BAD_COUNT = 3'd3,
        KIND_OVERFLOW  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] entry_index;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [15:0] value_c;
        logic [12:0] value_d;
    } result_t;

endpackage

`default_nettype wire

[design/sprite_sheet_layout_parser.sv]
// path: a result is written into the result queue, then moved to the output register that drives the m_ ports
// throughput: one byte per cycle; s_ready falls only while the four-entry result queue is full
// bytes that give no result (texture name, low bytes, most high bytes, halted or finished file) take no queue entry
// reset: aresetn synchronous active low, clears the parse position, the queue and m_valid
`timescale 1ns / 1ps
`default_nettype none

module sprite_sheet_layout_parser
    import sslp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_file_start,
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic [2:0]  m_kind,
    output      logic [15:0] m_entry_index,
    output      logic [15:0] m_value_a,
    output      logic [15:0] m_value_b,
    output      logic [15:0] m_value_c,
    output      logic [12:0] m_value_d
);

    logic    accept;
    logic    res_valid;
    result_t res;
    logic    q_full;
    logic    q_not_empty;
    logic    q_pop;
    result_t q_head;
    result_t out_data;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    sslp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .data_byte  (s_data_byte),
        .file_start (s_file_start),
        .res_valid  (res_valid),
        .res        (res)
    );

    sslp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && res_valid),
        .push_data (res),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    sslp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_data    (out_data)
    );

    assign m_kind        = out_data.kind;
    assign m_entry_index = out_data.entry_index;
    assign m_value_a     = out_data.value_a;
    assign m_value_b     = out_data.value_b;
    assign m_value_c     = out_data.value_c;
    assign m_value_d     = out_data.value_d;

endmodule

`default_nettype wire

[design/sslp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module sslp_front
    import sslp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    input  wire logic       file_start,
    output      logic       res_valid,
    output      result_t    res
);

    phase_t      phase_reg, phase_next, eff_phase;
    logic        high_reg, high_next, eff_high;
    logic [7:0]  low_reg, low_next, eff_low;
    logic [15:0] width_reg, width_next, eff_width;
    logic [15:0] height_reg, height_next, eff_height;
    logic [15:0] left_reg, left_next, eff_left;
    logic [15:0] entry_reg, entry_next, eff_entry;
    logic [7:0]  pos_reg, pos_next, eff_pos;
    logic [12:0] tx_reg, tx_next, eff_tx;
    logic [12:0] ty_reg, ty_next, eff_ty;
    logic [12:0] tw_reg, tw_next, eff_tw;
    logic [15:0] word;
    logic [15:0] left_dec;
    logic        word_phase;

    // start of a new file clears the parse before this byte is taken
    always_comb begin
        if (file_start) begin
            eff_phase  = PH_TEXCOUNT;
            eff_high   = 1'b0;
            eff_low    = '0;
            eff_width  = '0;
            eff_height = '0;
            eff_left   = '0;
            eff_entry  = '0;
            eff_pos    = '0;
            eff_tx     = '0;
            eff_ty     = '0;
            eff_tw     = '0;
        end else begin
            eff_phase  = phase_reg;
            eff_high   = high_reg;
            eff_low    = low_reg;
            eff_width  = width_reg;
            eff_height = height_reg;
            eff_left   = left_reg;
            eff_entry  = entry_reg;
            eff_pos    = pos_reg;
            eff_tx     = tx_reg;
            eff_ty     = ty_reg;
            eff_tw     = tw_reg;
        end
    end

    assign word       = {data_byte, eff_low};
    assign left_dec   = eff_left - 16'd1;
    assign word_phase = eff_phase inside {PH_TEXCOUNT, PH_WIDTH, PH_HEIGHT, PH_COUNT,
                                          PH_X, PH_Y, PH_W, PH_H};

    // next state
    always_comb begin
        phase_next  = eff_phase;
        high_next   = eff_high;
        low_next    = eff_low;
        width_next  = eff_width;
        height_next = eff_height;
        left_next   = eff_left;
        entry_next  = eff_entry;
        pos_next    = eff_pos;
        tx_next     = eff_tx;
        ty_next     = eff_ty;
        tw_next     = eff_tw;
        if (word_phase) begin
            if (!eff_high) begin
                low_next  = data_byte;
                high_next = 1'b1;
            end else begin
                high_next = 1'b0;
                case (eff_phase)
                    PH_TEXCOUNT: begin
                        phase_next = (word != 16'd1) ? PH_HALT : PH_TEXNAME;
                    end
                    PH_WIDTH: begin
                        width_next = word;
                        phase_next = PH_HEIGHT;
                    end
                    PH_HEIGHT: begin
                        height_next = word;
                        phase_next  = PH_COUNT;
                    end
                    PH_COUNT: begin
                        left_next  = word;
                        entry_next = '0;
                        pos_next   = '0;
                        phase_next = (word == 16'd0) ? PH_DONE : PH_NAME;
                    end
                    PH_X: begin
                        tx_next    = word[15:3];
                        phase_next = PH_Y;
                    end
                    PH_Y: begin
                        ty_next    = word[15:3];
                        phase_next = PH_W;
                    end
                    PH_W: begin
                        tw_next    = word[15:3];
                        phase_next = PH_H;
                    end
                    default: begin
                        entry_next = eff_entry + 16'd1;
                        left_next  = left_dec;
                        pos_next   = '0;
                        phase_next = (left_dec == 16'd0) ? PH_DONE : PH_NAME;
                    end
                endcase
            end
        end else if (eff_phase == PH_TEXNAME) begin
            if (data_byte == 8'd0) begin
                phase_next = PH_WIDTH;
            end
        end else if (eff_phase == PH_NAME) begin
            if (data_byte == 8'd0) begin
                phase_next = PH_X;
                high_next  = 1'b0;
            end else if (eff_pos < LAST_POS) begin
                pos_next = eff_pos + 8'd1;
            end
        end
    end

    // result
    always_comb begin
        res_valid       = 1'b0;
        res.kind        = KIND_HEADER;
        res.entry_index = '0;
        res.value_a     = '0;
        res.value_b     = '0;
        res.value_c     = '0;
        res.value_d     = '0;
        if (word_phase) begin
            if (eff_high) begin
                case (eff_phase)
                    PH_TEXCOUNT: begin
                        res_valid   = (word != 16'd1);
                        res.kind    = KIND_BAD_COUNT;
                        res.value_a = word;
                    end
                    PH_COUNT: begin
                        res_valid   = 1'b1;
                        res.kind    = KIND_HEADER;
                        res.value_a = eff_width;
                        res.value_b = eff_height;
                        res.value_c = word;
                    end
                    PH_H: begin
                        res_valid       = 1'b1;
                        res.kind        = KIND_GEOMETRY;
                        res.entry_index = eff_entry;
                        res.value_a     = {3'b000, eff_tx};
                        res.value_b     = {3'b000, eff_ty};
                        res.value_c     = {3'b000, eff_tw};
                        res.value_d     = word[15:3];
                    end
                    default: begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end else if (eff_phase == PH_NAME) begin
            res_valid       = 1'b1;
            res.entry_index = eff_entry;
            if (data_byte == 8'd0) begin
                res.kind    = KIND_NAME_BYTE;
                res.value_b = {8'd0, eff_pos};
            end else if (eff_pos >= LAST_POS) begin
                res.kind    = KIND_OVERFLOW;
                res.value_a = {8'd0, data_byte};
                res.value_b = {8'd0, LAST_POS};
            end else begin
                res.kind    = KIND_NAME_BYTE;
                res.value_a = {8'd0, data_byte};
                res.value_b = {8'd0, eff_pos};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TEXCOUNT;
            high_reg   <= 1'b0;
            low_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            left_reg   <= '0;
            entry_reg  <= '0;
            pos_reg    <= '0;
            tx_reg     <= '0;
            ty_reg     <= '0;
            tw_reg     <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            left_reg   <= left_next;
            entry_reg  <= entry_next;
            pos_reg    <= pos_next;
            tx_reg     <= tx_next;
            ty_reg     <= ty_next;
            tw_reg     <= tw_next;
        end
    end

endmodule

`default_nettype wire

[design/sslp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module sslp_queue
    import sslp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop,
    output      logic    full,
    output      logic    not_empty,
    output      result_t head
);

    result_t               mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count not advanced on push");

endmodule

`default_nettype wire

[design/sslp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module sslp_back
    import sslp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    q_not_empty,
    input  wire result_t q_head,
    output      logic    q_pop,
    output      logic    out_valid,
    input  wire logic    out_ready,
    output      result_t out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign q_pop      = q_not_empty && (!valid_reg || out_ready);
    assign valid_next = q_pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire
